// ===== sv/lsct_pkg.sv =====
// Shared widths, opcodes and constants for the line sensor threshold unit.
`timescale 1ns / 1ps
package lsct_pkg;

  localparam int DATA_W  = 12;
  localparam int CH_W    = 3;
  localparam int OP_W    = 3;
  localparam int MASK_W  = 8;
  localparam int SWEEP_W = 16;

  localparam int DEF_CHANNELS   = 8;
  localparam int DEF_FULL_SCALE = 4095;

  typedef logic [DATA_W-1:0]  data_t;
  typedef logic [CH_W-1:0]    chan_t;
  typedef logic [OP_W-1:0]    op_t;
  typedef logic [MASK_W-1:0]  mask_t;
  typedef logic [SWEEP_W-1:0] sweep_t;

  localparam op_t OP_SAMPLE        = 3'd0;
  localparam op_t OP_LOAD_WHITE    = 3'd1;
  localparam op_t OP_LOAD_BLACK    = 3'd2;
  localparam op_t OP_CAPTURE_WHITE = 3'd3;
  localparam op_t OP_CAPTURE_BLACK = 3'd4;
  localparam op_t OP_CLEAR_STATS   = 3'd5;

  localparam data_t TEST_DELTA_RST = 12'd80;
  localparam data_t LEVEL_MAX      = 12'hFFF;

  // Reciprocal of three in 16 fractional bits, exact for sums below 2^14.
  localparam int    THIRD_W = 16;
  localparam logic [THIRD_W-1:0] RECIP3 = 16'd21846;
  localparam int    SUM_W   = DATA_W + 2;

endpackage

// ===== sv/line_sensor_calibrated_threshold_unit.sv =====
// Per-channel calibration, hysteresis threshold and normalisation for a line sensor.
//
// Input words (opcode, channel, value, end_of_sweep) arrive on a valid/ready
// channel; each word produces exactly one result word on the output channel.
// The test delta register is written through cfg_write_en and cfg_wdata; the user
// must write it only while the block is idle, which the block does not enforce.
// Each word passes through the prep, multiply, check, divide and finish steps to
// a valid result. The divide step is a restoring divider that builds QW quotient
// bits, QW being the bit width of FULL_SCALE (12 for the default), one per cycle.
// One word is processed at a time; in_ready is high only while idle, so the next
// word is not taken until the previous result has been loaded.
// The result sits in an output register. A word may be accepted while a result
// is still waiting, but the new word holds in its final step, with no state
// changed, until the receiver has taken the previous result.
// Synchronous active-low reset returns every calibration level, the last raw
// values, the maxima and the baselines to zero, the minima to 4095, clears the
// line, test and sweep state and sets the test delta to 80.
`timescale 1ns / 1ps
module line_sensor_calibrated_threshold_unit #(
  parameter int CHANNELS   = lsct_pkg::DEF_CHANNELS,
  parameter int FULL_SCALE = lsct_pkg::DEF_FULL_SCALE
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  output logic             in_ready,
  input  lsct_pkg::op_t    in_opcode,
  input  lsct_pkg::chan_t  in_channel,
  input  lsct_pkg::data_t  in_value,
  input  logic             in_end_of_sweep,
  output logic             out_valid,
  input  logic             out_ready,
  output lsct_pkg::chan_t  out_channel_echo,
  output lsct_pkg::mask_t  out_digital_mask,
  output lsct_pkg::mask_t  out_test_mask_out,
  output lsct_pkg::data_t  out_normalized,
  output lsct_pkg::data_t  out_min_seen,
  output lsct_pkg::data_t  out_max_seen,
  output lsct_pkg::sweep_t out_sweep_count,
  input  logic             cfg_write_en,
  input  lsct_pkg::data_t  cfg_wdata
);
  import lsct_pkg::*;

  localparam int CW    = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
  localparam int QW    = $clog2(FULL_SCALE + 1);
  localparam int PW    = DATA_W + QW;
  localparam int CNT_W = $clog2(QW + 1);
  localparam int PRW   = SUM_W + THIRD_W;

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_PREP = 3'd1;
  localparam logic [2:0] S_MUL  = 3'd2;
  localparam logic [2:0] S_CHK  = 3'd3;
  localparam logic [2:0] S_DIV  = 3'd4;
  localparam logic [2:0] S_FIN  = 3'd5;

  logic [2:0]       state_r;
  logic [CNT_W-1:0] cnt_r;

  op_t    op_r;
  chan_t  ch_r;
  data_t  raw_r;
  logic   eos_r;
  data_t  test_delta_r;

  data_t  last_raw_r [CHANNELS];
  data_t  white_r    [CHANNELS];
  data_t  black_r    [CHANNELS];
  data_t  min_r      [CHANNELS];
  data_t  max_r      [CHANNELS];
  data_t  base_r     [CHANNELS];
  mask_t  line_r;
  mask_t  dev_r;
  logic   ready_r;
  sweep_t sweeps_r;

  data_t  upper_r, lower_r, num_r, den_r, rem_r;
  logic   pol_r, do_norm_r, dev_hit_r, set_r, clr_r, ovf_r;
  logic [QW-1:0] lo_r;

  logic   out_valid_r;
  chan_t  out_ch_r;
  mask_t  out_line_r, out_dev_r;
  data_t  out_norm_r, out_min_r, out_max_r;
  sweep_t out_sweep_r;

  logic [CW-1:0] idx;
  logic          ok;
  data_t         w_cur, b_cur, base_cur, min_cur, max_cur;
  logic [SUM_W-1:0] up_sum, lo_sum;
  logic [PRW-1:0]   up_prod, lo_prod;
  data_t         diff;
  logic [PW-1:0] prod;
  logic [DATA_W:0] rem2;
  logic          ge;
  data_t         rem_nxt;
  logic [QW-1:0] lo_nxt, norm_q;
  logic          commit;
  logic          is_sample;
  mask_t         line_nxt, dev_nxt;
  logic          ready_nxt;
  sweep_t        sweeps_nxt;
  data_t         min_nxt, max_nxt, norm_nxt;

  assign idx      = ch_r[CW-1:0];
  assign ok       = (32'(ch_r) < 32'(CHANNELS));
  assign w_cur    = white_r[idx];
  assign b_cur    = black_r[idx];
  assign base_cur = base_r[idx];
  assign min_cur  = min_r[idx];
  assign max_cur  = max_r[idx];

  assign up_sum  = SUM_W'(b_cur) + {1'b0, w_cur, 1'b0};
  assign lo_sum  = {1'b0, b_cur, 1'b0} + SUM_W'(w_cur);
  assign up_prod = PRW'(up_sum) * PRW'(RECIP3);
  assign lo_prod = PRW'(lo_sum) * PRW'(RECIP3);
  assign diff    = (raw_r >= base_cur) ? raw_r - base_cur : base_cur - raw_r;

  assign prod    = PW'(num_r) * PW'(FULL_SCALE);

  assign rem2    = {rem_r, lo_r[QW-1]};
  assign ge      = (rem2 >= {1'b0, den_r});
  assign rem_nxt = ge ? DATA_W'(rem2 - {1'b0, den_r}) : DATA_W'(rem2);
  assign lo_nxt  = {lo_r[QW-2:0], ge};

  assign commit    = (state_r == S_FIN) && (!out_valid_r || out_ready);
  assign is_sample = (op_r == OP_SAMPLE) && ok;

  always_comb begin
    line_nxt   = line_r;
    dev_nxt    = dev_r;
    ready_nxt  = ready_r;
    sweeps_nxt = sweeps_r;
    min_nxt    = min_cur;
    max_nxt    = max_cur;
    if (is_sample) begin
      if (set_r) begin
        line_nxt[ch_r] = 1'b1;
      end else if (clr_r) begin
        line_nxt[ch_r] = 1'b0;
      end
      if (raw_r < min_cur) begin
        min_nxt = raw_r;
      end
      if (raw_r > max_cur) begin
        max_nxt = raw_r;
      end
      if (ready_r) begin
        dev_nxt[ch_r] = dev_hit_r;
      end
      if (eos_r) begin
        if (!ready_r) begin
          ready_nxt = 1'b1;
          dev_nxt   = '0;
        end
        sweeps_nxt = sweeps_r + 1'b1;
      end
    end
    if (op_r == OP_CLEAR_STATS) begin
      min_nxt    = LEVEL_MAX;
      max_nxt    = '0;
      sweeps_nxt = '0;
    end
    if (!ok) begin
      min_nxt = '0;
      max_nxt = '0;
    end
    if (ovf_r || (32'(lo_r) > 32'(FULL_SCALE))) begin
      norm_q = QW'(FULL_SCALE);
    end else begin
      norm_q = lo_r;
    end
    norm_nxt = (is_sample && do_norm_r) ? DATA_W'(norm_q) : '0;
  end

  assign in_ready          = (state_r == S_IDLE);
  assign out_valid         = out_valid_r;
  assign out_channel_echo  = out_ch_r;
  assign out_digital_mask  = out_line_r;
  assign out_test_mask_out = out_dev_r;
  assign out_normalized    = out_norm_r;
  assign out_min_seen      = out_min_r;
  assign out_max_seen      = out_max_r;
  assign out_sweep_count   = out_sweep_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_IDLE;
      cnt_r        <= '0;
      out_valid_r  <= 1'b0;
      test_delta_r <= TEST_DELTA_RST;
      line_r       <= '0;
      dev_r        <= '0;
      ready_r      <= 1'b0;
      sweeps_r     <= '0;
      for (int i = 0; i < CHANNELS; i++) begin
        last_raw_r[i] <= '0;
        white_r[i]    <= '0;
        black_r[i]    <= '0;
        min_r[i]      <= LEVEL_MAX;
        max_r[i]      <= '0;
        base_r[i]     <= '0;
      end
    end else begin
      if (cfg_write_en) begin
        test_delta_r <= cfg_wdata;
      end
      if (out_valid_r && out_ready && !commit) begin
        out_valid_r <= 1'b0;
      end
      case (state_r)
        S_IDLE: begin
          if (in_valid) begin
            op_r    <= in_opcode;
            ch_r    <= in_channel;
            raw_r   <= in_value;
            eos_r   <= in_end_of_sweep;
            state_r <= S_PREP;
          end
        end
        S_PREP: begin
          upper_r   <= DATA_W'(up_prod >> THIRD_W);
          lower_r   <= DATA_W'(lo_prod >> THIRD_W);
          pol_r     <= (w_cur >= b_cur);
          dev_hit_r <= (diff > test_delta_r);
          if (w_cur >= b_cur) begin
            do_norm_r <= (w_cur > b_cur) && (raw_r > b_cur);
            num_r     <= raw_r - b_cur;
            den_r     <= w_cur - b_cur;
          end else begin
            do_norm_r <= (raw_r < b_cur);
            num_r     <= b_cur - raw_r;
            den_r     <= b_cur - w_cur;
          end
          state_r <= S_MUL;
        end
        S_MUL: begin
          rem_r   <= prod[PW-1:QW];
          lo_r    <= prod[QW-1:0];
          set_r   <= pol_r ? (raw_r > upper_r) : (raw_r < upper_r);
          clr_r   <= pol_r ? (raw_r < lower_r) : (raw_r > lower_r);
          state_r <= S_CHK;
        end
        S_CHK: begin
          ovf_r   <= (rem_r >= den_r);
          cnt_r   <= CNT_W'(QW - 1);
          state_r <= S_DIV;
        end
        S_DIV: begin
          rem_r <= rem_nxt;
          lo_r  <= lo_nxt;
          if (cnt_r == '0) begin
            state_r <= S_FIN;
          end else begin
            cnt_r <= cnt_r - 1'b1;
          end
        end
        S_FIN: begin
          if (commit) begin
            line_r   <= line_nxt;
            dev_r    <= dev_nxt;
            ready_r  <= ready_nxt;
            sweeps_r <= sweeps_nxt;
            if (op_r == OP_CLEAR_STATS) begin
              for (int i = 0; i < CHANNELS; i++) begin
                min_r[i] <= LEVEL_MAX;
                max_r[i] <= '0;
              end
            end else if (ok) begin
              min_r[idx] <= min_nxt;
              max_r[idx] <= max_nxt;
            end
            if (is_sample) begin
              last_raw_r[idx] <= raw_r;
              if (!ready_r) begin
                base_r[idx] <= raw_r;
              end
            end
            if ((op_r == OP_LOAD_WHITE) && ok) begin
              white_r[idx] <= raw_r;
            end
            if ((op_r == OP_LOAD_BLACK) && ok) begin
              black_r[idx] <= raw_r;
            end
            if (op_r == OP_CAPTURE_WHITE) begin
              for (int i = 0; i < CHANNELS; i++) begin
                white_r[i] <= last_raw_r[i];
              end
            end
            if (op_r == OP_CAPTURE_BLACK) begin
              for (int i = 0; i < CHANNELS; i++) begin
                black_r[i] <= last_raw_r[i];
              end
            end
            out_valid_r <= 1'b1;
            out_ch_r    <= ch_r;
            out_line_r  <= line_nxt;
            out_dev_r   <= dev_nxt;
            out_norm_r  <= norm_nxt;
            out_min_r   <= min_nxt;
            out_max_r   <= max_nxt;
            out_sweep_r <= sweeps_nxt;
            state_r     <= S_IDLE;
          end
        end
        default: begin
          state_r <= S_IDLE;
        end
      endcase
    end
  end

  // The partial remainder stays below the divisor while the quotient is built.
  a_rem_below_den: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_DIV && !ovf_r && den_r != '0) |-> (rem_r < den_r))
    else $error("divider remainder reached the divisor");

  // Finishing a word loads the output register and frees the input side.
  a_commit_loads_output: assert property (@(posedge clk) disable iff (!rst_n)
    commit |=> (out_valid_r && state_r == S_IDLE))
    else $error("finished word did not reach the output register");

  // An accepted word blocks further input until it has finished.
  a_one_word_in_flight: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready) |=> (!in_ready && state_r == S_PREP))
    else $error("input accepted while a word was in flight");

  // The result register is never overwritten while it still holds a word.
  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !out_ready && state_r == S_FIN) |=> (state_r == S_FIN))
    else $error("result overwritten while stalled");

endmodule
